### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define FSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define FSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/fsp_pkg.sv
// Types, constants and character helpers of the format specification parser.
package fsp_pkg;

  // Default depth of the queue between the classifier and the executor.
  localparam int FSP_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_L  = 8'h6C;
  localparam logic [7:0] CH_LC_J  = 8'h6A;
  localparam logic [7:0] CH_UC_L  = 8'h4C;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CH_LC_W  = 8'h77;

  localparam logic signed [15:0] NUM_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] NUM_NONE = -16'sd1;
  localparam logic [7:0]         CNT_MAX  = 8'hFF;

  // Length modifier codes.
  localparam logic [3:0] MOD_NONE = 4'd0;
  localparam logic [3:0] MOD_H    = 4'd1;
  localparam logic [3:0] MOD_HH   = 4'd2;
  localparam logic [3:0] MOD_L    = 4'd3;
  localparam logic [3:0] MOD_LL   = 4'd4;
  localparam logic [3:0] MOD_J    = 4'd5;
  localparam logic [3:0] MOD_JJ   = 4'd6;
  localparam logic [3:0] MOD_D    = 4'd7;
  localparam logic [3:0] MOD_W    = 4'd8;

  // Result status codes.
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EARLY = 1'b1;

  // Parse phases, in the order the specification is read.
  typedef enum logic [2:0] {
    PH_FLAGS     = 3'd0,
    PH_WSTART    = 3'd1,
    PH_WDIGITS   = 3'd2,
    PH_PSTART    = 3'd3,
    PH_PAFTERDOT = 3'd4,
    PH_PDIGITS   = 3'd5,
    PH_MOD       = 3'd6
  } fsp_phase_t;

  // What the executor does with one character.
  typedef enum logic [3:0] {
    ACT_FLAG,
    ACT_WSTAR,
    ACT_WDIG_FIRST,
    ACT_WDIG,
    ACT_DOT,
    ACT_PSTAR,
    ACT_PDIG_FIRST,
    ACT_PDIG,
    ACT_MOD,
    ACT_CODE
  } fsp_act_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    fsp_act_t          act;
    logic [7:0]        ch;
    logic signed [15:0] star_arg;
    logic              eot;
  } fsp_req_t;

  // One result item.
  typedef struct packed {
    logic               status;
    logic [7:0]         conv_code;
    logic [5:0]         flags;
    logic signed [15:0] field_width;
    logic signed [15:0] precision;
    logic [3:0]         length_mod;
    logic [7:0]         consumed_len;
  } fsp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_flag(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_APOS) ||
           (c == CH_ZERO) || (c == CH_HASH) || (c == CH_SPACE);
  endfunction

  function automatic logic is_mod_letter(input logic [7:0] c);
    return (c == CH_LC_H) || (c == CH_LC_L) || (c == CH_LC_J) ||
           (c == CH_UC_L) || (c == CH_UC_D) || (c == CH_LC_W);
  endfunction

endpackage

### rtl/fsp_front.sv
// Classifier: tracks the parse phase and tags each character with its action.
module fsp_front
  import fsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic signed [15:0] in_star_arg,
  input  logic               in_end_of_text,
  output logic               push_valid,
  output fsp_req_t           push_req,
  input  logic               push_ready
);

  fsp_phase_t phase_r, phase_nxt;
  fsp_act_t   act;
  fsp_phase_t act_phase;
  logic       dig;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign dig        = is_digit(in_ch);

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // A character skips forward to the first phase that takes it.
  always_comb begin
    if (phase_r == PH_FLAGS && is_flag(in_ch)) begin
      act = ACT_FLAG;       act_phase = PH_FLAGS;
    end else if (phase_r <= PH_WSTART && in_ch == CH_STAR) begin
      act = ACT_WSTAR;      act_phase = PH_PSTART;
    end else if (phase_r <= PH_WSTART && dig) begin
      act = ACT_WDIG_FIRST; act_phase = PH_WDIGITS;
    end else if (phase_r == PH_WDIGITS && dig) begin
      act = ACT_WDIG;       act_phase = PH_WDIGITS;
    end else if (phase_r <= PH_PSTART && in_ch == CH_DOT) begin
      act = ACT_DOT;        act_phase = PH_PAFTERDOT;
    end else if (phase_r == PH_PAFTERDOT && in_ch == CH_STAR) begin
      act = ACT_PSTAR;      act_phase = PH_MOD;
    end else if (phase_r == PH_PAFTERDOT && dig) begin
      act = ACT_PDIG_FIRST; act_phase = PH_PDIGITS;
    end else if (phase_r == PH_PDIGITS && dig) begin
      act = ACT_PDIG;       act_phase = PH_PDIGITS;
    end else if (is_mod_letter(in_ch)) begin
      act = ACT_MOD;        act_phase = PH_MOD;
    end else begin
      act = ACT_CODE;       act_phase = PH_FLAGS;
    end

    // A code or the end of text closes the specification.
    phase_nxt = phase_r;
    if (accept) begin
      if (act == ACT_CODE || in_end_of_text) begin
        phase_nxt = PH_FLAGS;
      end else begin
        phase_nxt = act_phase;
      end
    end

    push_req.act      = act;
    push_req.ch       = in_ch;
    push_req.star_arg = in_star_arg;
    push_req.eot      = in_end_of_text;
  end

endmodule

### rtl/fsp_queue.sv
// Small FIFO that decouples the classifier from the executor.
module fsp_queue
  import fsp_pkg::*;
#(
  parameter int Depth = FSP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  fsp_req_t push_req,
  output logic     push_ready,
  output logic     pop_valid,
  output fsp_req_t pop_req,
  input  logic     pop_ready
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  fsp_req_t          slot_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_req    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

### rtl/fsp_back.sv
// Executor: applies classified characters to the specification state and emits results.
module fsp_back
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  input  fsp_req_t    pop_req,
  output logic        pop_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output fsp_result_t out_res
);

  logic [5:0]         flags_r, flags_nxt;
  logic signed [15:0] width_r, width_nxt;
  logic signed [15:0] prec_r, prec_nxt;
  logic [3:0]         mod_r, mod_nxt;
  logic [1:0]         half_r, half_nxt;
  logic [1:0]         long_r, long_nxt;
  logic [1:0]         imax_r, imax_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  fsp_result_t        res_r, res_nxt;

  logic               emits;
  logic               do_pop;
  logic [7:0]         cnt_inc;
  logic [3:0]         mod_final;
  logic signed [15:0] star;

  // acc * 10 + digit, saturated to the largest short value.
  function automatic logic signed [15:0] add_digit(input logic signed [15:0] acc,
                                                   input logic [7:0] c);
    logic [19:0] sum;
    sum = {1'b0, acc[15:0], 3'b000} + {3'b000, acc[15:0], 1'b0} + {12'd0, c - CH_ZERO};
    return (sum > 20'(NUM_MAX)) ? NUM_MAX : sum[15:0];
  endfunction

  function automatic logic [5:0] flag_mask(input logic [7:0] c);
    logic [5:0] m;
    m = '0;
    m[0] = (c == CH_MINUS);
    m[1] = (c == CH_PLUS);
    m[2] = (c == CH_APOS);
    m[3] = (c == CH_ZERO);
    m[4] = (c == CH_HASH);
    m[5] = (c == CH_SPACE);
    return m;
  endfunction

  function automatic logic [1:0] bump(input logic [1:0] n);
    return (n < 2'd2) ? n + 2'd1 : 2'd2;
  endfunction

  assign star      = pop_req.star_arg;
  assign emits     = (pop_req.act == ACT_CODE) || pop_req.eot;
  assign pop_ready = !emits || !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign cnt_inc   = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 8'd1;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Doubled letters override the last letter, later checks winning.
  always_comb begin
    mod_final = mod_r;
    if (half_r > 2'd1) mod_final = MOD_HH;
    if (long_r > 2'd1) mod_final = MOD_LL;
    if (imax_r > 2'd1) mod_final = MOD_JJ;
  end

  // State update for one popped character.
  always_comb begin
    flags_nxt     = flags_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    mod_nxt       = mod_r;
    half_nxt      = half_r;
    long_nxt      = long_r;
    imax_nxt      = imax_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (do_pop) begin
      cnt_nxt = cnt_inc;
      unique case (pop_req.act)
        ACT_FLAG: begin
          flags_nxt = flags_r | flag_mask(pop_req.ch);
        end
        ACT_WSTAR: begin
          if (star[15]) begin
            flags_nxt[0] = ~flags_r[0];
            width_nxt    = (star == -16'sd32768) ? NUM_MAX : -star;
          end else begin
            width_nxt = star;
          end
        end
        ACT_WDIG_FIRST: width_nxt = add_digit('0, pop_req.ch);
        ACT_WDIG:       width_nxt = add_digit(width_r, pop_req.ch);
        ACT_DOT:        prec_nxt  = '0;
        ACT_PSTAR:      prec_nxt  = star[15] ? NUM_NONE : star;
        ACT_PDIG_FIRST: prec_nxt  = add_digit('0, pop_req.ch);
        ACT_PDIG:       prec_nxt  = add_digit(prec_r, pop_req.ch);
        ACT_MOD: begin
          priority if (pop_req.ch == CH_LC_H) begin
            mod_nxt  = MOD_H;
            half_nxt = bump(half_r);
          end else if (pop_req.ch == CH_LC_L) begin
            mod_nxt  = MOD_L;
            long_nxt = bump(long_r);
          end else if (pop_req.ch == CH_LC_J) begin
            mod_nxt  = MOD_J;
            imax_nxt = bump(imax_r);
          end else if (pop_req.ch == CH_UC_L) begin
            mod_nxt = MOD_LL;
          end else if (pop_req.ch == CH_UC_D) begin
            mod_nxt = MOD_D;
          end else begin
            mod_nxt = MOD_W;
          end
        end
        ACT_CODE: begin
          res_nxt.status       = STAT_OK;
          res_nxt.conv_code    = pop_req.ch;
          res_nxt.flags        = flags_r;
          res_nxt.field_width  = width_r;
          res_nxt.precision    = prec_r;
          res_nxt.length_mod   = mod_final;
          res_nxt.consumed_len = cnt_inc;
        end
        default: ;
      endcase

      // Text ended before a code: report an incomplete specification.
      if (pop_req.act != ACT_CODE && pop_req.eot) begin
        res_nxt.status       = STAT_EARLY;
        res_nxt.conv_code    = '0;
        res_nxt.flags        = '0;
        res_nxt.field_width  = NUM_NONE;
        res_nxt.precision    = NUM_NONE;
        res_nxt.length_mod   = MOD_NONE;
        res_nxt.consumed_len = cnt_inc;
      end

      // Either result restarts the parse.
      if (emits) begin
        out_valid_nxt = 1'b1;
        flags_nxt     = '0;
        width_nxt     = NUM_NONE;
        prec_nxt      = NUM_NONE;
        mod_nxt       = MOD_NONE;
        half_nxt      = '0;
        long_nxt      = '0;
        imax_nxt      = '0;
        cnt_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      width_r     <= NUM_NONE;
      prec_r      <= NUM_NONE;
      mod_r       <= MOD_NONE;
      half_r      <= '0;
      long_r      <= '0;
      imax_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      flags_r     <= flags_nxt;
      width_r     <= width_nxt;
      prec_r      <= prec_nxt;
      mod_r       <= mod_nxt;
      half_r      <= half_nxt;
      long_r      <= long_nxt;
      imax_r      <= imax_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

### rtl/printf_format_spec_parser_unit.sv
// Each accepted character passes through the queue; results come from the executor's register.
// Throughput: one character per cycle while the queue has room; the executor retires one
// queue entry per cycle and stalls only when a pending result meets a full output register.
// The queue depth (QueueDepth) sets how many characters can wait behind a stalled result.
// Reset is synchronous active low and returns the parser to the flags phase.
module printf_format_spec_parser_unit
  import fsp_pkg::*;
#(
  parameter int QueueDepth = FSP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic signed [15:0] in_star_arg,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [7:0]         out_conv_code,
  output logic               out_left_justify,
  output logic               out_plus_sign,
  output logic               out_group_thousands,
  output logic               out_zero_fill,
  output logic               out_alt_form,
  output logic               out_space_sign,
  output logic signed [15:0] out_field_width,
  output logic signed [15:0] out_precision,
  output logic [3:0]         out_length_mod,
  output logic [7:0]         out_consumed_len
);

  logic        push_valid, push_ready;
  fsp_req_t    push_req;
  logic        pop_valid, pop_ready;
  fsp_req_t    pop_req;
  fsp_result_t res;

  fsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_star_arg    (in_star_arg),
    .in_end_of_text (in_end_of_text),
    .push_valid     (push_valid),
    .push_req       (push_req),
    .push_ready     (push_ready)
  );

  fsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_req    (pop_req),
    .pop_ready  (pop_ready)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_req   (pop_req),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the result register onto the output ports.
  assign out_status          = res.status;
  assign out_conv_code       = res.conv_code;
  assign out_left_justify    = res.flags[0];
  assign out_plus_sign       = res.flags[1];
  assign out_group_thousands = res.flags[2];
  assign out_zero_fill       = res.flags[3];
  assign out_alt_form        = res.flags[4];
  assign out_space_sign      = res.flags[5];
  assign out_field_width     = res.field_width;
  assign out_precision       = res.precision;
  assign out_length_mod      = res.length_mod;
  assign out_consumed_len    = res.consumed_len;

endmodule

### rtl/fsp_checker.sv
// Port-level checker for the format specification parser, bound to the top level.
`include "assert_macros.svh"

module fsp_checker
  import fsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_ch,
  input logic signed [15:0] in_star_arg,
  input logic               in_end_of_text,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_status,
  input logic [7:0]         out_conv_code,
  input logic               out_left_justify,
  input logic               out_plus_sign,
  input logic               out_group_thousands,
  input logic               out_zero_fill,
  input logic               out_alt_form,
  input logic               out_space_sign,
  input logic signed [15:0] out_field_width,
  input logic signed [15:0] out_precision,
  input logic [3:0]         out_length_mod,
  input logic [7:0]         out_consumed_len
);

  logic stalled;
  logic early_out;
  logic early_defaults;
  logic result_in_range;

  assign stalled   = out_valid && !out_ready;
  assign early_out = out_valid && (out_status == STAT_EARLY);

  // An incomplete specification carries only default fields.
  assign early_defaults = (out_conv_code == '0) && (out_field_width == NUM_NONE) &&
                          (out_precision == NUM_NONE) && (out_length_mod == MOD_NONE) &&
                          !out_left_justify && !out_plus_sign && !out_group_thousands &&
                          !out_zero_fill && !out_alt_form && !out_space_sign;

  // Every result consumed at least one character, has a known modifier and no field below NUM_NONE.
  assign result_in_range = (out_consumed_len != '0) && (out_length_mod <= MOD_W) &&
                           (out_field_width >= NUM_NONE) && (out_precision >= NUM_NONE);

  // A pending result is held until it is taken.
  `FSP_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_field_width), "result not held")

  `FSP_ASSERT(a_early_defaults, early_out |-> early_defaults, "incomplete result has fields")

  `FSP_ASSERT(a_result_range, out_valid |-> result_in_range, "result field out of range")

  // Reset leaves no result pending.
  `FSP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind printf_format_spec_parser_unit fsp_checker u_fsp_checker (.*);
